/* rtl/wbtp_pkg.sv */
// Shared types, constants and command/status bundles for the window bit transpose packer.
`default_nettype none
package wbtp_pkg;

  localparam int MAX_HAPLOTYPES = 64;
  localparam int MAX_WINDOW     = 64;
  localparam int WORD_W         = 64;
  localparam int HAP_W          = 6;
  localparam int CNT_W          = 7;
  localparam int ALLELE_W       = 8;
  localparam int CFG_W          = 7;
  localparam int CFG_INDEX_W    = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HAPLOTYPE_COUNT = 1'b0,
    CFG_WINDOW_LENGTH   = 1'b1
  } cfg_index_t;

  typedef enum logic {
    ACT_ALLELE = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_t;

  typedef struct packed {
    logic                action;
    logic [ALLELE_W-1:0] allele;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic [HAP_W-1:0]  haplotype_index;
    logic [CNT_W-1:0]  records_in_window;
    logic              last_word;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_MERGE   = 2'd1,
    ST_EMIT_RD = 2'd2,
    ST_EMIT_LD = 2'd3
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic byte_rd;   // latch allele, read the current haplotype's word
    logic byte_wr;   // write back the merged word, advance positions
    logic emit_rd;   // read the word at the emit index
    logic emit_ld;   // load the output register with that word
    logic clear;     // drop the whole store and both positions
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic window_empty;  // no byte since the last emit
    logic window_full;   // the merge in progress completes the window
    logic emit_last;     // the emit index is the last emitted haplotype
    logic out_busy;      // output register still holds a beat
  } dp_sts_t;

  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/wbtp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wbtp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/wbtp_ctrl.sv */
// Sequencing state machine: byte merge and window emission.
`default_nettype none
module wbtp_ctrl
  import wbtp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  input  wire dp_sts_t  sts,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_acc = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_ALLELE) begin
            state_nxt = ST_MERGE;
          end else if (!sts.window_empty) begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_MERGE: begin
        state_nxt = sts.window_full ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        if (!sts.out_busy) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_nxt = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.byte_rd = in_acc && (in_action == ACT_ALLELE);
      end
      ST_MERGE: begin
        cmd.byte_wr = 1'b1;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = !sts.out_busy;
      end
      ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        cmd.clear   = sts.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/wbtp_dp.sv */
// Datapath: configuration, positions, word store and output register.
`default_nettype none
module wbtp_dp
  import wbtp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic [ALLELE_W-1:0]    in_allele,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_beat_t                   out_data
);

  logic [CFG_W-1:0]          hc_r, wl_r;
  logic [CFG_W-1:0]          hc_eff, wl_eff;
  logic [HAP_W-1:0]          hp_r;
  logic [CNT_W-1:0]          rp_r;
  logic [HAP_W-1:0]          emit_idx_r;
  logic [ALLELE_W-1:0]       allele_r;
  logic [MAX_HAPLOTYPES-1:0] valid_r;
  logic                      rd_valid_r;
  logic                      out_valid_r;
  out_beat_t                 out_r;

  logic [HAP_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] merged;
  logic [CNT_W-1:0]  hp_inc;
  logic [CNT_W-1:0]  rp_inc;
  logic              rec_done;

  assign hc_eff = clamp_reg(hc_r, CFG_W'(MAX_HAPLOTYPES));
  assign wl_eff = clamp_reg(wl_r, CFG_W'(MAX_WINDOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= CFG_W'(MAX_HAPLOTYPES);
      wl_r <= CFG_W'(MAX_WINDOW);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HAPLOTYPE_COUNT: hc_r <= cfg_data;
        CFG_WINDOW_LENGTH:   wl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raddr = cmd.emit_rd ? emit_idx_r : hp_r;

  wbtp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_HAPLOTYPES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.byte_wr),
    .waddr(hp_r),
    .wdata(merged),
    .raddr(raddr),
    .rdata(rdata)
  );

  // A word never written since the last emit reads as zero.
  assign word   = rd_valid_r ? rdata : '0;
  assign merged = word | ({{(WORD_W-ALLELE_W){1'b0}}, allele_r} << rp_r[HAP_W-1:0]);

  assign hp_inc   = {1'b0, hp_r} + CNT_W'(1);
  assign rp_inc   = rp_r + CNT_W'(1);
  assign rec_done = (hp_inc >= hc_eff);

  always_ff @(posedge clk) begin
    if (cmd.byte_rd) begin
      allele_r <= in_allele;
    end
    rd_valid_r <= valid_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      hp_r       <= '0;
      rp_r       <= '0;
      emit_idx_r <= '0;
    end else if (cmd.clear) begin
      valid_r    <= '0;
      hp_r       <= '0;
      rp_r       <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.byte_wr) begin
        valid_r[hp_r] <= 1'b1;
        if (rec_done) begin
          hp_r <= '0;
          rp_r <= rp_inc;
        end else begin
          hp_r <= hp_inc[HAP_W-1:0];
        end
      end
      if (cmd.emit_ld) begin
        emit_idx_r <= emit_idx_r + HAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_r.packed_word       <= word;
      out_r.haplotype_index   <= emit_idx_r;
      out_r.records_in_window <= rp_r;
      out_r.last_word         <= sts.emit_last;
    end
  end

  assign sts.window_empty = (hp_r == '0) && (rp_r == '0);
  assign sts.window_full  = rec_done && (rp_inc >= wl_eff);
  assign sts.emit_last    = (({1'b0, emit_idx_r} + CNT_W'(1)) == hc_eff);
  assign sts.out_busy     = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* rtl/window_bit_transpose_packer.sv */
// Top level of the window bit transpose packer: controller plus datapath.
`default_nettype none
// This block corner-turns a window of records into one 64-bit word per
// haplotype. Each allele beat is ORed into its haplotype's word, shifted left
// by the record's index in the window, so record k's allele starts at bit k.
// When window_length records are complete, or when a flush beat arrives with
// bytes pending, the words of haplotypes 0 to haplotype_count-1 leave as
// result beats in order, the last one flagged, each carrying the number of
// complete records; the store is then cleared. A flush with nothing gathered
// produces no beats. Register values of 0 act as 1 and values above 64 act
// as 64. An allele beat is handled in two steps, a read of the haplotype's
// word from the store memory and a write back of the merged word, and the
// next beat is only taken after the write back. Each word of a window is
// read from the store memory and then loaded into the output register; a
// read waits until the output register is empty. A further word's read only
// starts in the cycle after the previous beat has been taken, so the receiver
// holding off stalls the emission. No input beat is taken until the last word
// of a window is loaded. Clearing takes no extra time: per-word valid bits
// are dropped at once and an unwritten word reads as zero.
// Configuration writes are only legal while the block is idle.
module window_bit_transpose_packer
  import wbtp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_beat_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_beat_t                   out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns sequencing; it sees only the action bit of a beat.
  wbtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_data.action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds configuration, positions, the store and the output register.
  wbtp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_allele(in_data.allele),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
